>>> rtl/indexed_doubly_linked_list_assert.svh
// Assertion macros used by the checker file of the linked list block.
`ifndef INDEXED_DOUBLY_LINKED_LIST_ASSERT_SVH
`define INDEXED_DOUBLY_LINKED_LIST_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define IDLL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("indexed_doubly_linked_list assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define IDLL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("indexed_doubly_linked_list assertion failed");

`endif

>>> rtl/idll_pkg.sv
package idll_pkg;

    // Sizes of the slot tables and of the stored keys.
    localparam int SLOTS     = 16;
    localparam int KEY_BITS  = 16;
    localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LINK_BITS = $clog2(SLOTS + 1);

    typedef logic [KEY_BITS-1:0]  t_key;
    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [LINK_BITS-1:0] t_link;

    // A link equal to the slot count means no slot.
    localparam t_link NULL_LINK = LINK_BITS'(SLOTS);

    // Request actions.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic        action;
        logic [15:0] key_value;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
    } t_rsp;

    // True when a link names a real slot.
    function automatic logic is_slot(t_link l);
        return l < NULL_LINK;
    endfunction

endpackage

>>> rtl/indexed_doubly_linked_list.sv
// Insert: reads the free pool, claims the slot and stores the key (ST_POOL_RD), then
// links it behind the old tail when the list is not empty (ST_INS_TAIL); an insert is
// rejected without a pool read when the pool is empty. Remove walks the list from the
// head, one synchronous next-link memory read per entry visited. The result waits in
// ST_RESP until the output register is free; a new request is taken once it is registered.
// Reset is synchronous and active low: empty list, pool position i holds slot i,
// tracked by per-position flags, so no clearing pass is needed.
module indexed_doubly_linked_list (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  idll_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output idll_pkg::t_rsp o_out_data
);
    import idll_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POOL_RD,
        ST_INS_TAIL,
        ST_WALK,
        ST_RESP
    } t_state;

    // Control and result registers.
    t_state             r_state, n_state;
    t_key               r_key, n_key;
    t_slot              r_pos, n_pos;
    t_slot              r_slot, n_slot;
    t_link              r_head, n_head;
    t_link              r_tail, n_tail;
    logic [SLOTS-1:0]   r_pool_occ, n_pool_occ;
    logic [SLOTS-1:0]   r_pool_wr, n_pool_wr;
    logic [1:0]         r_res_status, n_res_status;
    t_slot              r_res_slot, n_res_slot;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out_data, n_out_data;

    // Slot tables and free pool.
    t_key               r_key_mem  [SLOTS];
    t_link              r_next_mem [SLOTS];
    t_link              r_prev_mem [SLOTS];
    t_slot              r_pool_mem [SLOTS];
    t_key               r_key_rdata;
    t_link              r_next_rdata;
    t_link              r_prev_rdata;
    t_slot              r_pool_rdata;

    // Memory port controls.
    logic               list_rd_en;
    t_slot              list_rd_addr;
    logic               pool_rd_en;
    logic               key_we;
    logic               next_we;
    t_slot              next_waddr;
    t_link              next_wdata;
    logic               prev_we;
    t_slot              prev_waddr;
    t_link              prev_wdata;
    logic               pool_we;
    t_slot              pool_waddr;

    // Helper values.
    t_slot              new_slot;
    t_slot              full_pos;
    t_slot              empty_pos;
    t_link              nx_clean;
    t_link              pv_clean;

    // Lowest set bit of a flag vector.
    function automatic t_slot lowest_set(logic [SLOTS-1:0] v);
        t_slot r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = SLOT_BITS'(i);
            end
        end
        return r;
    endfunction

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A pool position never written since reset holds its own index.
    assign new_slot  = r_pool_wr[r_pos] ? r_pool_rdata : r_pos;
    assign full_pos  = lowest_set(r_pool_occ);
    assign empty_pos = lowest_set(~r_pool_occ);
    assign nx_clean  = is_slot(r_next_rdata) ? r_next_rdata : NULL_LINK;
    assign pv_clean  = is_slot(r_prev_rdata) ? r_prev_rdata : NULL_LINK;

    // Next-state logic and memory port control.
    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_pos        = r_pos;
        n_slot       = r_slot;
        n_head       = r_head;
        n_tail       = r_tail;
        n_pool_occ   = r_pool_occ;
        n_pool_wr    = r_pool_wr;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        list_rd_en   = 1'b0;
        list_rd_addr = r_slot;
        pool_rd_en   = 1'b0;
        key_we       = 1'b0;
        next_we      = 1'b0;
        next_waddr   = r_slot;
        next_wdata   = NULL_LINK;
        prev_we      = 1'b0;
        prev_waddr   = r_slot;
        prev_wdata   = NULL_LINK;
        pool_we      = 1'b0;
        pool_waddr   = empty_pos;

        // The taker of the result empties the output register.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_key = t_key'(i_in_data.key_value);
                    if (i_in_data.action == ACT_INSERT) begin
                        if (r_pool_occ == '0) begin
                            n_res_status = STATUS_FULL;
                            n_res_slot   = '0;
                            n_state      = ST_RESP;
                        end else begin
                            n_pos      = full_pos;
                            pool_rd_en = 1'b1;
                            n_state    = ST_POOL_RD;
                        end
                    end else begin
                        if (!is_slot(r_head)) begin
                            n_res_status = STATUS_NOT_FOUND;
                            n_res_slot   = '0;
                            n_state      = ST_RESP;
                        end else begin
                            list_rd_en   = 1'b1;
                            list_rd_addr = r_head[SLOT_BITS-1:0];
                            n_slot       = r_head[SLOT_BITS-1:0];
                            n_state      = ST_WALK;
                        end
                    end
                end
            end

            // Claim the pooled slot, store the key and set its own links.
            ST_POOL_RD: begin
                key_we            = 1'b1;
                next_we           = 1'b1;
                next_waddr        = new_slot;
                next_wdata        = NULL_LINK;
                prev_we           = 1'b1;
                prev_waddr        = new_slot;
                prev_wdata        = is_slot(r_head) ? r_tail : NULL_LINK;
                n_pool_occ[r_pos] = 1'b0;
                n_slot            = new_slot;
                n_res_status      = STATUS_DONE;
                n_res_slot        = new_slot;
                if (!is_slot(r_head)) begin
                    n_head  = LINK_BITS'(new_slot);
                    n_tail  = LINK_BITS'(new_slot);
                    n_state = ST_RESP;
                end else begin
                    n_state = ST_INS_TAIL;
                end
            end

            // Hook the new slot behind the old tail.
            ST_INS_TAIL: begin
                next_we    = 1'b1;
                next_waddr = r_tail[SLOT_BITS-1:0];
                next_wdata = LINK_BITS'(r_slot);
                n_tail     = LINK_BITS'(r_slot);
                n_state    = ST_RESP;
            end

            // One list entry per cycle: compare, then unlink, follow next or report not found.
            ST_WALK: begin
                if (r_key_rdata == r_key) begin
                    if (!is_slot(r_prev_rdata)) begin
                        n_head = nx_clean;
                    end else begin
                        next_we    = 1'b1;
                        next_waddr = r_prev_rdata[SLOT_BITS-1:0];
                        next_wdata = nx_clean;
                    end
                    if (is_slot(r_next_rdata)) begin
                        prev_we    = 1'b1;
                        prev_waddr = r_next_rdata[SLOT_BITS-1:0];
                        prev_wdata = pv_clean;
                    end else begin
                        n_tail = pv_clean;
                    end
                    if (r_pool_occ != '1) begin
                        pool_we               = 1'b1;
                        n_pool_occ[empty_pos] = 1'b1;
                        n_pool_wr[empty_pos]  = 1'b1;
                    end
                    n_res_status = STATUS_DONE;
                    n_res_slot   = r_slot;
                    n_state      = ST_RESP;
                end else if (is_slot(r_next_rdata)) begin
                    list_rd_en   = 1'b1;
                    list_rd_addr = r_next_rdata[SLOT_BITS-1:0];
                    n_slot       = r_next_rdata[SLOT_BITS-1:0];
                end else begin
                    n_res_status = STATUS_NOT_FOUND;
                    n_res_slot   = '0;
                    n_state      = ST_RESP;
                end
            end

            // Hand the result to the output register once it is free.
            ST_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out_data.status = r_res_status;
                    n_out_data.slot   = 4'(r_res_slot);
                    n_state           = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= NULL_LINK;
            r_tail      <= NULL_LINK;
            r_pool_occ  <= '1;
            r_pool_wr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_pool_occ  <= n_pool_occ;
            r_pool_wr   <= n_pool_wr;
            r_out_valid <= n_out_valid;
        end
        r_key        <= n_key;
        r_pos        <= n_pos;
        r_slot       <= n_slot;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_data   <= n_out_data;
    end

    // Key, next and prev tables share one read address.
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[new_slot] <= r_key;
        end
        if (list_rd_en) begin
            r_key_rdata <= r_key_mem[list_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_waddr] <= next_wdata;
        end
        if (list_rd_en) begin
            r_next_rdata <= r_next_mem[list_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            r_prev_mem[prev_waddr] <= prev_wdata;
        end
        if (list_rd_en) begin
            r_prev_rdata <= r_prev_mem[list_rd_addr];
        end
    end

    // Free pool contents; occupancy lives in the flag registers.
    always_ff @(posedge i_clk) begin
        if (pool_we) begin
            r_pool_mem[pool_waddr] <= r_slot;
        end
        if (pool_rd_en) begin
            r_pool_rdata <= r_pool_mem[full_pos];
        end
    end

endmodule

>>> rtl/idll_checker.sv
`include "indexed_doubly_linked_list_assert.svh"

module idll_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input idll_pkg::t_req i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input idll_pkg::t_rsp o_out_data
);
    import idll_pkg::*;

    // A result that is not taken stays in place.
    `IDLL_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // Only the defined status codes appear.
    `IDLL_ASSERT_IMPL(a_status_code, o_out_valid, o_out_data.status <= STATUS_NOT_FOUND)

    // A rejected request reports slot zero.
    `IDLL_ASSERT_IMPL(a_fail_slot, o_out_valid && o_out_data.status != STATUS_DONE, o_out_data.slot == 4'd0)

    // The block works on one request at a time.
    `IDLL_ASSERT_NEXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind indexed_doubly_linked_list idll_checker u_idll_checker (.*);
